// File: src/rgb_to_ycbcr_bt2020_subsampler_core_macros.svh
// Assertion macros used by the converter RTL (the output buffer in ycc_out).
`ifndef RGB_TO_YCBCR_BT2020_SUBSAMPLER_CORE_MACROS_SVH
`define RGB_TO_YCBCR_BT2020_SUBSAMPLER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define YCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define YCC_ASSERT_NEXT(label, cond, next, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (next)) else $error(msg);
`else
`define YCC_ASSERT(label, prop, msg)
`define YCC_ASSERT_NEXT(label, cond, next, msg)
`endif
`endif

// File: src/ycc_pkg.sv
// Shared types, constants and configuration helpers of the RGB to YCbCr converter.
`timescale 1ns / 1ps
package ycc_pkg;

  localparam int LANES     = 3;
  localparam int LANE_Y    = 0;
  localparam int LANE_CB   = 1;
  localparam int LANE_CR   = 2;

  localparam int COMP_W    = 16;
  localparam int POS_W     = 13;
  localparam int FH_W      = 14;
  localparam int DEPTH_W   = 5;
  localparam int CM_W      = 2;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int SMP_W     = 16;
  localparam int SHIFT_W   = 4;

  localparam int SUM_W     = 30;
  localparam int DIFF_W    = SUM_W + 1;
  localparam int DVD_W     = 40;
  localparam int NUM_W     = DVD_W + 1;
  localparam int DVS_W     = 32;
  localparam int QUO_W     = 17;
  localparam int CMP_W     = DVS_W + QUO_W - 1;
  localparam int SCL_W     = QUO_W + 8;

  typedef enum logic [CM_W-1:0] {
    CM_444 = 2'd0,
    CM_422 = 2'd1,
    CM_420 = 2'd2,
    CM_400 = 2'd3
  } chroma_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_BITS      = 2'd0,
    REG_OUT_BITS     = 2'd1,
    REG_CHROMA_MODE  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [DEPTH_W-1:0] IN_BITS_RST      = 5'd8;
  localparam logic [DEPTH_W-1:0] OUT_BITS_RST     = 5'd10;
  localparam chroma_mode_t       CHROMA_MODE_RST  = CM_444;
  localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST = 14'd1080;
  localparam logic [FH_W-1:0]    MAX_DIM          = 14'd8192;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN        = 5'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX        = 5'd16;

  // BT.2020 luma weights scaled by 10000.
  localparam logic [12:0] COEF_R = 13'd2627;
  localparam logic [12:0] COEF_G = 13'd6780;
  localparam logic [12:0] COEF_B = 13'd593;
  localparam logic [13:0] SCALE  = 14'd10000;

  // Rounding is done as floor((2N + D) / 2D), so the numerator weights are doubled
  // and each offset holds twice the level offset times D plus D, all per unit of maxv.
  localparam logic [8:0]  Y_NUM_K = 9'd438;
  localparam logic [8:0]  C_NUM_K = 9'd448;
  localparam logic [22:0] OFF_K [LANES] = '{23'd330000, 23'd4835198, 23'd3789722};
  localparam logic [15:0] DIV_K [LANES] = '{16'd20000, 16'd37628, 16'd29492};

  typedef logic [DVD_W-1:0] dvd_t;
  typedef logic [DVS_W-1:0] dvs_t;
  typedef logic [QUO_W-1:0] quo_t;
  typedef logic [SMP_W-1:0] smp_t;

  typedef struct packed {
    dvd_t [LANES-1:0]   offset;
    dvs_t [LANES-1:0]   divisor;
    smp_t               max_out;
    logic [SHIFT_W-1:0] shift;
  } ycc_cfg_t;

  typedef struct packed {
    smp_t luma;
    smp_t cb;
    smp_t cr;
    logic cv;
  } ycc_item_t;

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] v);
    sat_depth = (v < DEPTH_MIN) ? DEPTH_MIN : ((v > DEPTH_MAX) ? DEPTH_MAX : v);
  endfunction

  function automatic ycc_cfg_t derive_cfg(input logic [DEPTH_W-1:0] in_bits,
                                          input logic [DEPTH_W-1:0] out_bits);
    logic [DEPTH_W-1:0] ib;
    logic [DEPTH_W-1:0] ob;
    logic [COMP_W-1:0]  maxv;
    ycc_cfg_t           c;
    ib   = sat_depth(in_bits);
    ob   = sat_depth(out_bits);
    maxv = COMP_W'((17'd1 << ib) - 17'd1);
    for (int l = 0; l < LANES; l++) begin
      c.offset[l]  = DVD_W'(OFF_K[l]) * DVD_W'(maxv);
      c.divisor[l] = DVS_W'(DIV_K[l]) * DVS_W'(maxv);
    end
    c.max_out = SMP_W'((17'd1 << ob) - 17'd1);
    c.shift   = SHIFT_W'(ob - DEPTH_MIN);
    derive_cfg = c;
  endfunction

endpackage

// File: src/ycc_front.sv
// Front pipeline: weighted sum, color differences, rounding numerators and chroma flag.
`timescale 1ns / 1ps
module ycc_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [ycc_pkg::COMP_W-1:0]             in_red,
  input  logic [ycc_pkg::COMP_W-1:0]             in_green,
  input  logic [ycc_pkg::COMP_W-1:0]             in_blue,
  input  logic [ycc_pkg::POS_W-1:0]              in_column,
  input  logic [ycc_pkg::POS_W-1:0]              in_row,
  input  ycc_pkg::chroma_mode_t                  chroma_mode,
  input  logic [ycc_pkg::FH_W-1:0]               frame_height,
  input  ycc_pkg::ycc_cfg_t                      cfg,
  output logic                                   valid_o,
  output logic                                   cv_o,
  output ycc_pkg::dvd_t [ycc_pkg::LANES-1:0]     dvd_o
);
  import ycc_pkg::*;

  logic                     even_col;
  logic                     last_row;
  logic                     cv_nxt;
  logic [SUM_W-1:0]         sum_nxt;
  logic [SUM_W-1:0]         tb_nxt;
  logic [SUM_W-1:0]         tr_nxt;

  logic                     va_r;
  logic                     cva_r;
  logic [SUM_W-1:0]         sum_a_r;
  logic [SUM_W-1:0]         tb_a_r;
  logic [SUM_W-1:0]         tr_a_r;

  dvd_t                     yn_nxt;
  logic signed [DIFF_W-1:0] diff_b_nxt;
  logic signed [DIFF_W-1:0] diff_r_nxt;

  logic                     vb_r;
  logic                     cvb_r;
  dvd_t                     yn_b_r;
  logic signed [DIFF_W-1:0] diff_b_r;
  logic signed [DIFF_W-1:0] diff_r_r;

  logic signed [NUM_W-1:0]  num_b;
  logic signed [NUM_W-1:0]  num_r;
  dvd_t [LANES-1:0]         dvd_nxt;

  logic                     vc_r;
  logic                     cvc_r;
  dvd_t [LANES-1:0]         dvd_c_r;

  always_comb begin
    even_col = ~in_column[0];
    last_row = (frame_height != '0) && (frame_height <= MAX_DIM) &&
               ({1'b0, in_row} == frame_height - 14'd1);
    unique case (chroma_mode)
      CM_444: cv_nxt = 1'b1;
      CM_422: cv_nxt = even_col;
      CM_420: cv_nxt = even_col && (in_row[0] || last_row);
      CM_400: cv_nxt = 1'b0;
    endcase
    sum_nxt = SUM_W'(COEF_R) * SUM_W'(in_red) + SUM_W'(COEF_G) * SUM_W'(in_green) +
              SUM_W'(COEF_B) * SUM_W'(in_blue);
    tb_nxt  = SUM_W'(SCALE) * SUM_W'(in_blue);
    tr_nxt  = SUM_W'(SCALE) * SUM_W'(in_red);
  end

  always_comb begin
    yn_nxt     = DVD_W'(Y_NUM_K) * DVD_W'(sum_a_r) + cfg.offset[LANE_Y];
    diff_b_nxt = $signed({1'b0, tb_a_r}) - $signed({1'b0, sum_a_r});
    diff_r_nxt = $signed({1'b0, tr_a_r}) - $signed({1'b0, sum_a_r});
  end

  // A negative numerator rounds to zero or below, which clamps to zero; a zero
  // dividend gives the same result.
  always_comb begin
    num_b = NUM_W'(diff_b_r) * $signed(NUM_W'(C_NUM_K)) +
            $signed(NUM_W'(cfg.offset[LANE_CB]));
    num_r = NUM_W'(diff_r_r) * $signed(NUM_W'(C_NUM_K)) +
            $signed(NUM_W'(cfg.offset[LANE_CR]));
    dvd_nxt[LANE_Y]  = yn_b_r;
    dvd_nxt[LANE_CB] = num_b[NUM_W-1] ? '0 : num_b[DVD_W-1:0];
    dvd_nxt[LANE_CR] = num_r[NUM_W-1] ? '0 : num_r[DVD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cva_r    <= cv_nxt;
      sum_a_r  <= sum_nxt;
      tb_a_r   <= tb_nxt;
      tr_a_r   <= tr_nxt;
      cvb_r    <= cva_r;
      yn_b_r   <= yn_nxt;
      diff_b_r <= diff_b_nxt;
      diff_r_r <= diff_r_nxt;
      cvc_r    <= cvb_r;
      dvd_c_r  <= dvd_nxt;
    end
  end

  assign valid_o = vc_r;
  assign cv_o    = cvc_r;
  assign dvd_o   = dvd_c_r;

endmodule

// File: src/ycc_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes side by side.
`timescale 1ns / 1ps
module ycc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_i,
  input  logic                               cv_i,
  input  ycc_pkg::dvd_t [ycc_pkg::LANES-1:0] dvd_i,
  input  ycc_pkg::dvs_t [ycc_pkg::LANES-1:0] dvs_i,
  output logic                               valid_o,
  output logic                               cv_o,
  output ycc_pkg::quo_t [ycc_pkg::LANES-1:0] quo_o
);
  import ycc_pkg::*;

  dvd_t [LANES-1:0] rem_src [QUO_W];
  quo_t [LANES-1:0] quo_src [QUO_W];
  logic             v_src   [QUO_W];
  logic             cv_src  [QUO_W];

  dvd_t [LANES-1:0] rem_r   [QUO_W];
  quo_t [LANES-1:0] quo_r   [QUO_W];
  logic             v_r     [QUO_W];
  logic             cv_r    [QUO_W];

  assign rem_src[0] = dvd_i;
  assign quo_src[0] = '0;
  assign v_src[0]   = valid_i;
  assign cv_src[0]  = cv_i;

  for (genvar st = 0; st < QUO_W; st++) begin : g_stage
    localparam int QPos = QUO_W - 1 - st;

    dvd_t [LANES-1:0] rem_nxt;
    quo_t [LANES-1:0] quo_nxt;

    if (st > 0) begin : g_link
      assign rem_src[st] = rem_r[st-1];
      assign quo_src[st] = quo_r[st-1];
      assign v_src[st]   = v_r[st-1];
      assign cv_src[st]  = cv_r[st-1];
    end

    always_comb begin
      logic [CMP_W-1:0] shifted;
      logic [CMP_W-1:0] rem_ext;
      logic             ge;
      for (int l = 0; l < LANES; l++) begin
        shifted    = CMP_W'(dvs_i[l]) << QPos;
        rem_ext    = CMP_W'(rem_src[st][l]);
        ge         = rem_ext >= shifted;
        rem_nxt[l] = ge ? DVD_W'(rem_ext - shifted) : rem_src[st][l];
        quo_nxt[l] = {quo_src[st][l][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[st] <= 1'b0;
      end else if (en) begin
        v_r[st] <= v_src[st];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st] <= rem_nxt;
        quo_r[st] <= quo_nxt;
        cv_r[st]  <= cv_src[st];
      end
    end
  end

  assign valid_o = v_r[QUO_W-1];
  assign cv_o    = cv_r[QUO_W-1];
  assign quo_o   = quo_r[QUO_W-1];

endmodule

// File: src/ycc_out.sv
// Scaling, clamping and the two-entry output buffer of the converter.
`timescale 1ns / 1ps
`include "rgb_to_ycbcr_bt2020_subsampler_core_macros.svh"
module ycc_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  logic                               cv_i,
  input  ycc_pkg::quo_t [ycc_pkg::LANES-1:0] quo_i,
  input  ycc_pkg::ycc_cfg_t                  cfg,
  output logic                               hold_o,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ycc_pkg::SMP_W-1:0]          out_luma,
  output logic [ycc_pkg::SMP_W-1:0]          out_chroma_blue,
  output logic [ycc_pkg::SMP_W-1:0]          out_chroma_red,
  output logic                               out_chroma_valid
);
  import ycc_pkg::*;

  ycc_item_t res;
  ycc_item_t out_r;
  ycc_item_t skid_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  logic      load_out;
  logic      load_skid;

  function automatic smp_t clamp_scale(input quo_t q, input smp_t mx,
                                       input logic [SHIFT_W-1:0] sh);
    logic [SCL_W-1:0] t;
    t = SCL_W'(q) << sh;
    clamp_scale = (t > SCL_W'(mx)) ? mx : t[SMP_W-1:0];
  endfunction

  always_comb begin
    res.luma = clamp_scale(quo_i[LANE_Y], cfg.max_out, cfg.shift);
    res.cb   = cv_i ? clamp_scale(quo_i[LANE_CB], cfg.max_out, cfg.shift) : '0;
    res.cr   = cv_i ? clamp_scale(quo_i[LANE_CR], cfg.max_out, cfg.shift) : '0;
    res.cv   = cv_i;
  end

  // While the skid entry is full the pipeline is frozen and only the skid drains.
  always_comb begin
    load_out  = skid_valid_r ? !out_stall : (!out_valid_r || !out_stall);
    load_skid = !skid_valid_r && out_valid_r && out_stall && valid_i;
    if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = out_stall;
    end else begin
      out_valid_nxt  = (!out_valid_r || !out_stall) ? valid_i : 1'b1;
      skid_valid_nxt = load_skid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign hold_o           = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_luma         = out_r.luma;
  assign out_chroma_blue  = out_r.cb;
  assign out_chroma_red   = out_r.cr;
  assign out_chroma_valid = out_r.cv;

  `YCC_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid entry full while output is empty")
  `YCC_ASSERT_NEXT(a_skid_on_stall, !skid_valid_r && !(out_valid_r && out_stall), !skid_valid_r, "skid entry filled without a stalled output")
  `YCC_ASSERT(a_chroma_zero, out_valid_r && !out_r.cv |-> out_r.cb == '0 && out_r.cr == '0, "chroma samples not zero outside the chroma plane")

endmodule

// File: src/rgb_to_ycbcr_bt2020_subsampler_core.sv
// Top level of the BT.2020 RGB to limited-range YCbCr converter with chroma marks.
`timescale 1ns / 1ps
// The converter takes one RGB pixel per clock while in_stall is low and returns one
// result per pixel holding Y, Cb, Cr and a flag that marks the chroma samples as part
// of the subsampled plane; where the flag is low both chroma samples are zero. A
// result passes through the front pipeline of weighting and numerator arithmetic, a
// 17-stage divider that settles one quotient bit per stage for all three components
// in parallel, and one output register. The sustained rate is one pixel per clock
// while the output is not stalled, set by the fully pipelined divider. A two-entry
// output buffer absorbs a stall on the result side, and in_stall rises only once
// both entries are full. Configuration writes must be issued while no pixel is in
// flight; the depth-dependent constants are registered from the written values.
module rgb_to_ycbcr_bt2020_subsampler_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ycc_pkg::COMP_W-1:0]     in_red,
  input  logic [ycc_pkg::COMP_W-1:0]     in_green,
  input  logic [ycc_pkg::COMP_W-1:0]     in_blue,
  input  logic [ycc_pkg::POS_W-1:0]      in_column,
  input  logic [ycc_pkg::POS_W-1:0]      in_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ycc_pkg::SMP_W-1:0]      out_luma,
  output logic [ycc_pkg::SMP_W-1:0]      out_chroma_blue,
  output logic [ycc_pkg::SMP_W-1:0]      out_chroma_red,
  output logic                           out_chroma_valid,
  input  logic                           cfg_we,
  input  logic [ycc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ycc_pkg::CFG_W-1:0]      cfg_wdata
);
  import ycc_pkg::*;

  logic [DEPTH_W-1:0] in_bits_r;
  logic [DEPTH_W-1:0] out_bits_r;
  chroma_mode_t       chroma_mode_r;
  logic [FH_W-1:0]    frame_height_r;
  ycc_cfg_t           derived_r;

  logic               hold;
  logic               en;
  logic               front_valid;
  logic               front_cv;
  dvd_t [LANES-1:0]   front_dvd;
  logic               div_valid;
  logic               div_cv;
  quo_t [LANES-1:0]   div_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_bits_r      <= IN_BITS_RST;
      out_bits_r     <= OUT_BITS_RST;
      chroma_mode_r  <= CHROMA_MODE_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IN_BITS:      in_bits_r      <= cfg_wdata[DEPTH_W-1:0];
        REG_OUT_BITS:     out_bits_r     <= cfg_wdata[DEPTH_W-1:0];
        REG_CHROMA_MODE:  chroma_mode_r  <= chroma_mode_t'(cfg_wdata[CM_W-1:0]);
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      derived_r <= derive_cfg(IN_BITS_RST, OUT_BITS_RST);
    end else begin
      derived_r <= derive_cfg(in_bits_r, out_bits_r);
    end
  end

  assign en       = !hold;
  assign in_stall = hold;

  ycc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_column    (in_column),
    .in_row       (in_row),
    .chroma_mode  (chroma_mode_r),
    .frame_height (frame_height_r),
    .cfg          (derived_r),
    .valid_o      (front_valid),
    .cv_o         (front_cv),
    .dvd_o        (front_dvd)
  );

  ycc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (front_valid),
    .cv_i    (front_cv),
    .dvd_i   (front_dvd),
    .dvs_i   (derived_r.divisor),
    .valid_o (div_valid),
    .cv_o    (div_cv),
    .quo_o   (div_quo)
  );

  ycc_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid_i          (div_valid),
    .cv_i             (div_cv),
    .quo_i            (div_quo),
    .cfg              (derived_r),
    .hold_o           (hold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_luma         (out_luma),
    .out_chroma_blue  (out_chroma_blue),
    .out_chroma_red   (out_chroma_red),
    .out_chroma_valid (out_chroma_valid)
  );

endmodule
